[rtl/tws_pkg.sv]
`default_nettype none

package tws_pkg;

  // sample and table geometry
  localparam int SW           = 24;
  localparam int TANH_ENTRIES = 256;
  localparam int FRAC_W       = SW - 1;
  localparam int TAB_AW       = $clog2(TANH_ENTRIES);
  localparam int TAB_NW       = $clog2(TANH_ENTRIES + 1);

  // register widths
  localparam int DRIVE_W = 16;
  localparam int LEVEL_W = 15;
  localparam int COEF_W  = 17;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  // shaper datapath widths
  localparam int ARG_W = SW + DRIVE_W - 10;
  localparam int POS_W = ARG_W + TAB_NW;
  localparam int IDX_W = POS_W - (SW + 2);
  localparam int FR_W  = 16;

  // filter datapath widths
  localparam int STATE_SHIFT = 6;
  localparam int ST_W        = SW + STATE_SHIFT + 2;
  localparam int DIFF_W      = ST_W + 1;
  localparam int PROD_W      = DIFF_W + COEF_W + 1;
  localparam int OUT_SHIFT   = 13 + STATE_SHIFT;
  localparam int OUT_Y_W     = PROD_W - OUT_SHIFT;

  // queue between shaper and filter
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SW-1:0]             TANH_TOP = {1'b0, {(SW-1){1'b1}}};
  localparam logic [COEF_W-1:0]         COEF_ONE = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [OUT_Y_W-1:0] Y_HI     = OUT_Y_W'(TANH_TOP);
  localparam logic signed [OUT_Y_W-1:0] Y_LO     = ~Y_HI;
  localparam logic [63:0]               EXP_M1_Q32 = 64'd1580030169;

  // register reset values
  localparam logic [DRIVE_W-1:0] DRIVE_RST = DRIVE_W'(1024);
  localparam logic [LEVEL_W-1:0] LEVEL_RST = LEVEL_W'(4096);
  localparam logic [COEF_W-1:0]  DC_RST    = '0;
  localparam logic [COEF_W-1:0]  LP_RST    = COEF_ONE;

  typedef enum logic [1:0] {
    REG_DRIVE_GAIN,
    REG_OUTPUT_LEVEL,
    REG_DC_COEF,
    REG_LOWPASS_COEF
  } reg_idx_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive_gain;
    logic [LEVEL_W-1:0] output_level;
    logic [COEF_W-1:0]  dc_coefficient;
    logic [COEF_W-1:0]  lowpass_coefficient;
  } tws_cfg_t;

  typedef struct packed {
    logic signed [SW:0] shaped;
    logic               block_end;
  } tws_word_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_LOOK,
    F_INTERP,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DC,
    B_DCU,
    B_LP,
    B_LPU,
    B_OUTM,
    B_OUT
  } back_state_t;

  // shift-subtract division, evaluated while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^-f for f in [0,1), Q32, alternating series
  function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
    logic [63:0] sum;
    logic [63:0] mag;
    sum = '0;
    mag = 64'd1 << 32;
    for (int n = 0; n < 24; n++) begin
      if ((n % 2) != 0) sum = sum - mag;
      else sum = sum + mag;
      mag = udiv64((mag * f) >> 32, 64'(n + 1));
    end
    return sum;
  endfunction

  // tanh(8*idx/N) in Q1.(SW-1), rounded to nearest
  function automatic logic [SW-1:0] tanh_entry(input int unsigned idx);
    logic [63:0] t;
    logic [63:0] k;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    t = (64'(idx) << 36) / 64'(TANH_ENTRIES);
    k = t >> 32;
    e = exp_neg_frac(t & 64'hFFFF_FFFF);
    // whole part of 2u stays below 16 over the table span
    for (int j = 0; j < 16; j++) begin
      if (64'(j) < k) e = (e * EXP_M1_Q32) >> 32;
    end
    num = (64'd1 << 32) - e;
    den = (64'd1 << 32) + e;
    q   = udiv64((num << FRAC_W) + (den >> 1), den);
    return q[SW-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/tws_intf.sv]
`default_nettype none

// input word channel
interface tws_in_if import tws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [SW-1:0] sample_in;
  logic              block_end_in;

  modport source (output valid, output sample_in, output block_end_in, input ready);
  modport sink (input valid, input sample_in, input block_end_in, output ready);
endinterface

// result word channel
interface tws_out_if import tws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [SW-1:0] sample_out;
  logic              block_end_out;

  modport source (output valid, output sample_out, output block_end_out, input ready);
  modport sink (input valid, input sample_out, input block_end_out, output ready);
endinterface

`default_nettype wire

[rtl/tws_front.sv]
`default_nettype none

module tws_front import tws_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  tws_in_if.sink        in_chan,
  input  wire tws_cfg_t cfg,
  input  wire logic     q_full,
  output logic          q_push,
  output tws_word_t     q_word
);

  front_state_t state_r, state_nxt;

  logic accept;
  logic ld_arg;
  logic ld_look;
  logic ld_shp;

  logic                  neg_r;
  logic                  be_r;
  logic [SW-1:0]         abs_r;
  logic [ARG_W-1:0]      arg_r;
  logic [SW-1:0]         a_r;
  logic [SW-1:0]         d_r;
  logic [FR_W-1:0]       fr_r;
  logic                  ovf_r;
  logic signed [SW:0]    shp_r;

  logic [SW-1:0]         raw_u;
  logic [SW-1:0]         raw_abs;
  logic [SW+DRIVE_W-1:0] drive_prod;
  logic [POS_W-1:0]      pos;
  logic [IDX_W-1:0]      idx;
  logic                  idx_ovf;
  logic [TAB_AW-1:0]     idx_lo;
  logic [TAB_AW-1:0]     idx_hi;
  logic                  idx_last;
  logic [SW-1:0]         ent_a;
  logic [SW-1:0]         ent_b;
  logic [SW+FR_W-1:0]    interp;
  logic [SW-1:0]         mag;
  logic [SW:0]           mag_ext;
  logic [SW:0]           shp;

  logic [SW-1:0]         tanh_tab [TANH_ENTRIES];

  // tanh curve, built at elaboration
  for (genvar g = 0; g < TANH_ENTRIES; g++) begin : g_tab
    localparam logic [SW-1:0] ENT = tanh_entry(g);
    assign tanh_tab[g] = ENT;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:   if (in_chan.valid) state_nxt = F_MUL;
      F_MUL:    state_nxt = F_LOOK;
      F_LOOK:   state_nxt = F_INTERP;
      F_INTERP: state_nxt = F_PUSH;
      F_PUSH:   if (!q_full) state_nxt = F_IDLE;
      default:  state_nxt = F_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_chan.ready = 1'b0;
    ld_arg        = 1'b0;
    ld_look       = 1'b0;
    ld_shp        = 1'b0;
    q_push        = 1'b0;
    case (state_r)
      F_IDLE:   in_chan.ready = 1'b1;
      F_MUL:    ld_arg = 1'b1;
      F_LOOK:   ld_look = 1'b1;
      F_INTERP: ld_shp = 1'b1;
      F_PUSH:   q_push = 1'b1;
      default:  in_chan.ready = 1'b0;
    endcase
  end

  assign accept = in_chan.valid && in_chan.ready;

  // magnitude of the incoming sample
  assign raw_u   = in_chan.sample_in;
  assign raw_abs = raw_u[SW-1] ? (SW'(0) - raw_u) : raw_u;

  // drive gain, Q6.10
  assign drive_prod = (SW+DRIVE_W)'(abs_r) * (SW+DRIVE_W)'(cfg.drive_gain);

  // table position, neighbors and fraction
  assign pos      = POS_W'(arg_r) * POS_W'(TANH_ENTRIES);
  assign idx      = pos[POS_W-1:SW+2];
  assign idx_ovf  = idx >= IDX_W'(TANH_ENTRIES);
  assign idx_lo   = idx[TAB_AW-1:0];
  assign idx_last = idx_lo == TAB_AW'(TANH_ENTRIES - 1);
  assign idx_hi   = idx_last ? '0 : idx_lo + 1'b1;

  always_comb begin
    ent_a = tanh_tab[idx_lo];
    ent_b = idx_last ? TANH_TOP : tanh_tab[idx_hi];
    if (ent_b < ent_a) ent_b = ent_a;
  end

  // linear interpolation and sign restore
  assign interp  = (SW+FR_W)'(d_r) * (SW+FR_W)'(fr_r);
  assign mag     = ovf_r ? TANH_TOP : a_r + interp[SW+FR_W-1:FR_W];
  assign mag_ext = {1'b0, mag};
  assign shp     = neg_r ? ((SW+1)'(0) - mag_ext) : mag_ext;

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r <= raw_u[SW-1];
      abs_r <= raw_abs;
      be_r  <= in_chan.block_end_in;
    end
    if (ld_arg) begin
      arg_r <= drive_prod[SW+DRIVE_W-1:10];
    end
    if (ld_look) begin
      a_r   <= ent_a;
      d_r   <= ent_b - ent_a;
      fr_r  <= pos[SW+1 -: FR_W];
      ovf_r <= idx_ovf;
    end
    if (ld_shp) begin
      shp_r <= $signed(shp);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign q_word.shaped    = shp_r;
  assign q_word.block_end = be_r;

endmodule

`default_nettype wire

[rtl/tws_queue.sv]
`default_nettype none

module tws_queue import tws_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire tws_word_t wr_word,
  output logic           full,
  input  wire logic      pop,
  output tws_word_t      rd_word,
  output logic           empty
);

  tws_word_t       slot_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r;
  logic [QP_W-1:0] rd_ptr_r;
  logic [QC_W-1:0] cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full    = cnt_r == QC_W'(QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_word = slot_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/tws_back.sv]
`default_nettype none

module tws_back import tws_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire tws_cfg_t  cfg,
  input  wire logic      q_empty,
  input  wire tws_word_t q_word,
  output logic           q_pop,
  tws_out_if.source      out_chan
);

  back_state_t state_r, state_nxt;

  logic dc_clr;
  logic dc_upd;
  logic lp_upd;
  logic ld_prod;
  logic out_slot_free;
  logic out_load;

  logic signed [ST_W-1:0]    x_r;
  logic signed [ST_W-1:0]    dc_r;
  logic signed [ST_W-1:0]    lp_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      be_r;
  logic                      out_valid_r;
  logic signed [SW-1:0]      out_sample_r;
  logic                      out_be_r;

  logic [COEF_W-1:0]         dc_coef;
  logic [COEF_W-1:0]         lp_coef;
  logic signed [DIFF_W-1:0]  mul_a;
  logic [COEF_W-1:0]         mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [ST_W-1:0]    step;
  logic signed [ST_W-1:0]    dc_sum;
  logic signed [OUT_Y_W-1:0] y;
  logic signed [OUT_Y_W-1:0] y_sat;

  assign out_slot_free = !out_valid_r || out_chan.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (!q_empty) state_nxt = B_DC;
      B_DC:    state_nxt = (cfg.dc_coefficient != '0) ? B_DCU : B_LP;
      B_DCU:   state_nxt = B_LP;
      B_LP:    state_nxt = B_LPU;
      B_LPU:   state_nxt = B_OUTM;
      B_OUTM:  state_nxt = B_OUT;
      B_OUT:   if (out_slot_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = 1'b0;
    dc_clr   = 1'b0;
    dc_upd   = 1'b0;
    lp_upd   = 1'b0;
    ld_prod  = 1'b0;
    out_load = 1'b0;
    case (state_r)
      B_IDLE:  q_pop = !q_empty;
      B_DC: begin
        ld_prod = 1'b1;
        dc_clr  = cfg.dc_coefficient == '0;
      end
      B_DCU:   dc_upd = 1'b1;
      B_LP:    ld_prod = 1'b1;
      B_LPU:   lp_upd = 1'b1;
      B_OUTM:  ld_prod = 1'b1;
      B_OUT:   out_load = out_slot_free;
      default: q_pop = 1'b0;
    endcase
  end

  // coefficients above one act as one
  assign dc_coef = cfg.dc_coefficient[COEF_W-1] ? COEF_ONE : cfg.dc_coefficient;
  assign lp_coef = cfg.lowpass_coefficient[COEF_W-1] ? COEF_ONE : cfg.lowpass_coefficient;

  // operand select for the shared multiplier
  always_comb begin
    case (state_r)
      B_DC: begin
        mul_a = {x_r[ST_W-1], x_r} - {dc_r[ST_W-1], dc_r};
        mul_b = dc_coef;
      end
      B_LP: begin
        mul_a = {x_r[ST_W-1], x_r} - {lp_r[ST_W-1], lp_r};
        mul_b = lp_coef;
      end
      B_OUTM: begin
        mul_a = {lp_r[ST_W-1], lp_r};
        mul_b = COEF_W'(cfg.output_level);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  // floor of product over 2^16, and filter updates
  assign step   = prod_r[ST_W+15:16];
  assign dc_sum = dc_r + step;

  // output gain with floor and saturation
  assign y     = prod_r[PROD_W-1:OUT_SHIFT];
  assign y_sat = (y > Y_HI) ? Y_HI : ((y < Y_LO) ? Y_LO : y);

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_r  <= {q_word.shaped[SW], q_word.shaped, {STATE_SHIFT{1'b0}}};
      be_r <= q_word.block_end;
    end else if (dc_upd) begin
      x_r  <= x_r - dc_sum;
    end
    if (ld_prod) begin
      prod_r <= mul_p;
    end
    if (out_load) begin
      out_sample_r <= y_sat[SW-1:0];
      out_be_r     <= be_r;
    end
  end

  // filter state and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      dc_r        <= '0;
      lp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (dc_clr) begin
        dc_r <= '0;
      end else if (dc_upd) begin
        dc_r <= dc_sum;
      end
      if (lp_upd) begin
        lp_r <= lp_r + step;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.sample_out    = out_sample_r;
  assign out_chan.block_end_out = out_be_r;

endmodule

`default_nettype wire

[rtl/tanh_waveshaper_dc_block_lowpass_core.sv]
`default_nettype none

// Tanh soft clipper followed by an optional DC blocker, a one-pole low-pass and an
// output level gain, one signed 24-bit Q1.23 sample per word. The shaper front end
// takes a word and then steps through the drive multiply, the tanh table lookup,
// the interpolation multiply and the push into a two-word queue, taking no new word
// until that push is done. The filter back end pops a word and runs the DC tracker,
// the low-pass and the level gain one after another through a single shared 33x18
// multiplier, skipping the DC tracker update when the blocker is off, and pops no
// new word until its result is loaded into the output register once that is free.
// A finished word waits in the output register while the next is worked on.
// Registers sit on an APB port at byte addresses 0 (drive gain, Q6.10), 4 (output
// level, Q2.13), 8 (DC coefficient, Q1.16, zero disables the blocker) and 12
// (low-pass coefficient, Q1.16); write them only while no word is in flight.

module tanh_waveshaper_dc_block_lowpass_core import tws_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  tws_in_if.sink                 in_chan,
  tws_out_if.source              out_chan,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  tws_cfg_t  cfg_r;
  reg_idx_t  reg_idx;
  logic      cfg_wr;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  tws_word_t q_wr_word;
  tws_word_t q_rd_word;

  // register access
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drive_gain          <= DRIVE_RST;
      cfg_r.output_level        <= LEVEL_RST;
      cfg_r.dc_coefficient      <= DC_RST;
      cfg_r.lowpass_coefficient <= LP_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DRIVE_GAIN:   cfg_r.drive_gain          <= pwdata[DRIVE_W-1:0];
        REG_OUTPUT_LEVEL: cfg_r.output_level        <= pwdata[LEVEL_W-1:0];
        REG_DC_COEF:      cfg_r.dc_coefficient      <= pwdata[COEF_W-1:0];
        REG_LOWPASS_COEF: cfg_r.lowpass_coefficient <= pwdata[COEF_W-1:0];
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_DRIVE_GAIN:   prdata = CFG_DW'(cfg_r.drive_gain);
      REG_OUTPUT_LEVEL: prdata = CFG_DW'(cfg_r.output_level);
      REG_DC_COEF:      prdata = CFG_DW'(cfg_r.dc_coefficient);
      REG_LOWPASS_COEF: prdata = CFG_DW'(cfg_r.lowpass_coefficient);
      default:          prdata = '0;
    endcase
  end

  // shaper front end
  tws_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_word  (q_wr_word)
  );

  // queue between front and back
  tws_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_word (q_wr_word),
    .full    (q_full),
    .pop     (q_pop),
    .rd_word (q_rd_word),
    .empty   (q_empty)
  );

  // filter back end
  tws_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_word   (q_rd_word),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
